// ===== hdl/top_k_min_heap_selector_assert.svh =====
// ----------------------------------------------------------------------------
// top_k_min_heap_selector_assert.svh
// Assertion macros used by the heap selector checker. Both sample on the
// rising edge of clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOP_K_MIN_HEAP_SELECTOR_ASSERT_SVH
`define TOP_K_MIN_HEAP_SELECTOR_ASSERT_SVH

// Same-cycle implication
`define TKH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TKH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tkh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkh_pkg
// Types, constants and helpers for the top-k min-heap selector.
// ----------------------------------------------------------------------------
package tkh_pkg;

  // Heap storage
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Configuration
  localparam int KEEP_W             = 6;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd20;
  localparam int CMP_W              = ((CNT_W > KEEP_W) ? CNT_W : KEEP_W) + 1;
  localparam int PADDR_W            = 3;
  localparam int PDATA_W            = 32;
  localparam logic [PADDR_W-3:0] REG_KEEP_COUNT = '0;

  // Field widths
  localparam int SCORE_W = 32;
  localparam int POS_W   = 24;

  // Item modes
  localparam logic [1:0] MODE_OFFER = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_DRAIN = 2'd2;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [POS_W-1:0]          left;
    logic [POS_W-1:0]          right;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFER,
    ST_DN_ISS,
    ST_DN_CMP,
    ST_UP_ISS,
    ST_UP_CMP,
    ST_REPLY,
    ST_DR_SCAN,
    ST_DR_EMIT
  } state_t;

  // Drain order: higher score first, then smaller left, then smaller right
  function automatic logic entry_before(entry_t a, entry_t b);
    if (a.score != b.score) return $signed(a.score) > $signed(b.score);
    if (a.left != b.left) return a.left < b.left;
    return a.right < b.right;
  endfunction

endpackage

// ===== hdl/top_k_min_heap_selector.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_selector
// Keeps the keep_count largest scored entries in a binary min-heap held in a
// 32-entry RAM; offers, clears and largest-first drains.
// ----------------------------------------------------------------------------
// One item at a time; in_ready is high only while the block is idle. All heap
// work runs through one RAM (one write port, two registered read ports), with
// a read issue state and a compare state per heap level. An offer kept while
// the heap is below k sifts up by up to 5 levels; an offer that replaces the
// minimum first sifts the last entry down from the root, then sifts the new
// entry up. A rejected offer or a clear goes straight to the reply. A drain
// of n entries runs a selection scan over the RAM for every result. The
// result register lets the next item enter as soon as the last result is
// loaded. Empty RAM slots are never read into a result, so there is no
// clearing pass after reset.
module top_k_min_heap_selector import tkh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input items
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic signed [SCORE_W-1:0] in_offer_value,
  input  logic [POS_W-1:0]          in_offer_left,
  input  logic [POS_W-1:0]          in_offer_right,
  // result items
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_accepted,
  output logic                      out_entry_valid,
  output logic signed [SCORE_W-1:0] out_value,
  output logic [POS_W-1:0]          out_left,
  output logic [POS_W-1:0]          out_right,
  output logic                      out_last,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  // Heap RAM, slot i (1-based) at address i-1
  entry_t heap_mem [CAPACITY];

  state_t              state_r, state_nxt;
  logic [KEEP_W-1:0]   keep_r;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    now_r, now_nxt;
  entry_t              x_r, x_nxt;
  entry_t              m_r, m_nxt;
  logic                acc_r, acc_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pidx_r, pidx_nxt;
  entry_t              best_r, best_nxt;
  logic [ADDR_W-1:0]   bidx_r, bidx_nxt;
  logic                have_r, have_nxt;
  logic [CNT_W-1:0]    emit_r, emit_nxt;
  logic [CAPACITY-1:0] taken_r, taken_nxt;

  // RAM ports
  logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr, mem_wa;
  entry_t              rd_a_q, rd_b_q, mem_wd;
  logic                mem_we;

  // Result register
  logic                out_valid_r;
  logic                out_acc_r, out_ev_r, out_last_r;
  entry_t              out_ent_r;
  logic                out_load, ld_acc, ld_ev, ld_last;
  entry_t              ld_ent;
  logic                out_free;

  // Derived values
  logic [CMP_W-1:0]    keep_ext, cap_ext, k_eff;
  logic [CNT_W-1:0]    held_m1, held_p1, now_m1, par_m1, emit_p1;
  logic [CNT_W:0]      son, son_m1, son_p1, sidx, held_ext;
  logic                use_b, scan_issue, emit_last;
  entry_t              sel_ent;
  logic                cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite &
                  (paddr[PADDR_W-1:2] == REG_KEEP_COUNT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_KEEP_COUNT) ? PDATA_W'(keep_r) : '0;

  // Effective k: zero acts as one, clamp to capacity
  assign keep_ext = CMP_W'(keep_r);
  assign cap_ext  = CMP_W'(CAPACITY);
  assign k_eff    = (keep_r == '0) ? CMP_W'(1) :
                    ((keep_ext > cap_ext) ? cap_ext : keep_ext);

  // Index arithmetic
  assign held_m1  = held_r - CNT_W'(1);
  assign held_p1  = held_r + CNT_W'(1);
  assign now_m1   = now_r - CNT_W'(1);
  assign par_m1   = (now_r >> 1) - CNT_W'(1);
  assign emit_p1  = emit_r + CNT_W'(1);
  assign son      = {now_r, 1'b0};
  assign son_m1   = son - (CNT_W+1)'(1);
  assign son_p1   = son + (CNT_W+1)'(1);
  assign held_ext = (CNT_W+1)'(held_r);

  // Sift-down child choice: right child only if present and smaller
  assign use_b    = (son < held_ext) && ($signed(rd_b_q.score) < $signed(rd_a_q.score));
  assign sel_ent  = use_b ? rd_b_q : rd_a_q;
  assign sidx     = use_b ? son_p1 : son;

  assign scan_issue = scan_r < held_r;
  assign emit_last  = emit_p1 == held_r;
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    now_nxt   = now_r;
    x_nxt     = x_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    scan_nxt  = scan_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = scan_r[ADDR_W-1:0];
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    have_nxt  = have_r;
    emit_nxt  = emit_r;
    taken_nxt = taken_r;
    rd_a_addr = '0;
    rd_b_addr = '0;
    mem_we    = 1'b0;
    mem_wa    = now_m1[ADDR_W-1:0];
    mem_wd    = x_r;
    out_load  = 1'b0;
    ld_acc    = 1'b0;
    ld_ev     = 1'b0;
    ld_ent    = '0;
    ld_last   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        // root and last slot, ready for an offer next cycle
        rd_a_addr = '0;
        rd_b_addr = held_m1[ADDR_W-1:0];
        if (in_valid) begin
          x_nxt = '{score: in_offer_value, left: in_offer_left, right: in_offer_right};
          case (in_mode)
            MODE_OFFER: state_nxt = ST_OFFER;
            MODE_CLEAR: begin
              held_nxt  = '0;
              acc_nxt   = 1'b0;
              state_nxt = ST_REPLY;
            end
            MODE_DRAIN: begin
              acc_nxt = 1'b0;
              if (held_r == '0) begin
                state_nxt = ST_REPLY;
              end else begin
                taken_nxt = '0;
                scan_nxt  = '0;
                have_nxt  = 1'b0;
                emit_nxt  = '0;
                state_nxt = ST_DR_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_OFFER: begin
        if (CMP_W'(held_r) < k_eff) begin
          // room left: plain push
          held_nxt  = held_p1;
          now_nxt   = held_p1;
          acc_nxt   = 1'b1;
          state_nxt = ST_UP_ISS;
        end else if (held_r == '0 || $signed(x_r.score) <= $signed(rd_a_q.score)) begin
          acc_nxt   = 1'b0;
          state_nxt = ST_REPLY;
        end else begin
          // pop the minimum: last entry sifts down from the root
          m_nxt     = rd_b_q;
          held_nxt  = held_m1;
          now_nxt   = CNT_W'(1);
          acc_nxt   = 1'b1;
          state_nxt = ST_DN_ISS;
        end
      end

      ST_DN_ISS: begin
        if (son <= held_ext) begin
          rd_a_addr = son_m1[ADDR_W-1:0];
          rd_b_addr = son[ADDR_W-1:0];
          state_nxt = ST_DN_CMP;
        end else begin
          mem_we    = 1'b1;
          mem_wd    = m_r;
          held_nxt  = held_p1;
          now_nxt   = held_p1;
          state_nxt = ST_UP_ISS;
        end
      end

      ST_DN_CMP: begin
        mem_we = 1'b1;
        if ($signed(sel_ent.score) >= $signed(m_r.score)) begin
          mem_wd    = m_r;
          held_nxt  = held_p1;
          now_nxt   = held_p1;
          state_nxt = ST_UP_ISS;
        end else begin
          mem_wd    = sel_ent;
          now_nxt   = sidx[CNT_W-1:0];
          state_nxt = ST_DN_ISS;
        end
      end

      ST_UP_ISS: begin
        if (now_r > CNT_W'(1)) begin
          rd_a_addr = par_m1[ADDR_W-1:0];
          state_nxt = ST_UP_CMP;
        end else begin
          mem_we    = 1'b1;
          state_nxt = ST_REPLY;
        end
      end

      ST_UP_CMP: begin
        mem_we = 1'b1;
        if ($signed(rd_a_q.score) <= $signed(x_r.score)) begin
          state_nxt = ST_REPLY;
        end else begin
          mem_wd    = rd_a_q;
          now_nxt   = now_r >> 1;
          state_nxt = ST_UP_ISS;
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_acc    = acc_r;
          state_nxt = ST_IDLE;
        end
      end

      ST_DR_SCAN: begin
        // one slot read per cycle, data compared the cycle after
        rd_a_addr = scan_r[ADDR_W-1:0];
        pend_nxt  = scan_issue;
        if (scan_issue) scan_nxt = scan_r + CNT_W'(1);
        if (pend_r && !taken_r[pidx_r] && (!have_r || entry_before(rd_a_q, best_r))) begin
          best_nxt = rd_a_q;
          bidx_nxt = pidx_r;
          have_nxt = 1'b1;
        end
        if (!scan_issue) state_nxt = ST_DR_EMIT;
      end

      ST_DR_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          ld_ev             = 1'b1;
          ld_ent            = best_r;
          ld_last           = emit_last;
          taken_nxt[bidx_r] = 1'b1;
          emit_nxt          = emit_p1;
          if (emit_last) begin
            held_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            scan_nxt  = '0;
            have_nxt  = 1'b0;
            state_nxt = ST_DR_SCAN;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keep_r      <= KEEP_RESET;
      held_r      <= '0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      emit_r      <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      have_r  <= have_nxt;
      emit_r  <= emit_nxt;
      taken_r <= taken_nxt;
      if (cfg_wr) keep_r <= pwdata[KEEP_W-1:0];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    x_r    <= x_nxt;
    m_r    <= m_nxt;
    acc_r  <= acc_nxt;
    scan_r <= scan_nxt;
    pidx_r <= pidx_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    if (out_load) begin
      out_acc_r  <= ld_acc;
      out_ev_r   <= ld_ev;
      out_ent_r  <= ld_ent;
      out_last_r <= ld_last;
    end
  end

  // Heap RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) heap_mem[mem_wa] <= mem_wd;
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // Result port
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_entry_valid = out_ev_r;
  assign out_value       = out_ent_r.score;
  assign out_left        = out_ent_r.left;
  assign out_right       = out_ent_r.right;
  assign out_last        = out_last_r;

endmodule

// ===== hdl/tkh_checker.sv =====
// ----------------------------------------------------------------------------
// tkh_checker
// Port-level checks for the top-k min-heap selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_min_heap_selector_assert.svh"

module tkh_checker import tkh_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_mode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic                      out_entry_valid,
  input logic signed [SCORE_W-1:0] out_value,
  input logic [POS_W-1:0]          out_left,
  input logic [POS_W-1:0]          out_right,
  input logic                      out_last
);

  // An accepted offer result is always a single, entry-less item
  `TKH_ASSERT_IMP(a_offer_single, out_valid && out_accepted, !out_entry_valid && out_last, "offer result carries an entry or is not last")

  // Only a drain produces more than one result
  `TKH_ASSERT_IMP(a_multi_is_drain, out_valid && !out_last, out_entry_valid, "non-final result without an entry")

  // Results without an entry carry zero payload
  `TKH_ASSERT_IMP(a_empty_zero, out_valid && !out_entry_valid, out_value == '0 && out_left == '0 && out_right == '0, "payload set on entry-less result")

  // Any real item makes the block busy next cycle
  `TKH_ASSERT_NXT(a_busy_after_item, in_valid && in_ready && (in_mode == MODE_OFFER || in_mode == MODE_CLEAR || in_mode == MODE_DRAIN), !in_ready, "ready stayed high after an item")

  // A stalled result holds
  `TKH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last), "stalled result changed")

endmodule

bind top_k_min_heap_selector tkh_checker u_tkh_checker (.*);

// ===== tb/sv/top_k_min_heap_selector_test.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_selector_test
// Self-checking bench for the top-k min-heap selector. Offers, clears, drains
// and ignored items go in over a valid/ready channel. A local min-heap model
// tracks the kept entries and queues the results each item should produce.
// Returned results are checked field by field, in order. The keep count is
// rewritten over the APB port while the block is idle, extremes included.
// Sender gaps, receiver stalls and one long receiver hold-off are mixed in.
// ----------------------------------------------------------------------------
module top_k_min_heap_selector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tkh_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         LIMIT_CYCLES  = 600000;
  localparam int         REPORT_MAX    = 10;

  // one result item as the block presents it
  typedef struct packed {
    logic                      accepted;
    logic                      entry_valid;
    logic signed [SCORE_W-1:0] value;
    logic [POS_W-1:0]          left;
    logic [POS_W-1:0]          right;
    logic                      last;
  } heap_reply_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                in_mode;
  logic signed [SCORE_W-1:0] in_offer_value;
  logic [POS_W-1:0]          in_offer_left;
  logic [POS_W-1:0]          in_offer_right;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_accepted;
  logic                      out_entry_valid;
  logic signed [SCORE_W-1:0] out_value;
  logic [POS_W-1:0]          out_left;
  logic [POS_W-1:0]          out_right;
  logic                      out_last;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // shadow heap and keep count
  entry_t            kept_heap [1:CAPACITY];
  int                held_entries = 0;
  logic [KEEP_W-1:0] keep_setting = KEEP_RESET;
  heap_reply_t       due_replies [$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_request   = 0;
  int          hold_left      = 0;
  int          cycle_count    = 0;
  int          mismatch_count = 0;
  heap_reply_t seen_reply;
  heap_reply_t want_reply;

  top_k_min_heap_selector uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_offer_value  (in_offer_value),
    .in_offer_left   (in_offer_left),
    .in_offer_right  (in_offer_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_entry_valid (out_entry_valid),
    .out_value       (out_value),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Heap model
  // --------------------------------------------------------------------------

  // drain order: higher score, then smaller left, then smaller right
  function automatic bit outranks(entry_t a, entry_t b);
    if (a.score != b.score) return $signed(a.score) > $signed(b.score);
    if (a.left != b.left) return a.left < b.left;
    return a.right < b.right;
  endfunction

  function automatic void queue_reply(bit acc, bit valid, entry_t e, bit last);
    heap_reply_t r;
    r.accepted    = acc;
    r.entry_valid = valid;
    r.value       = e.score;
    r.left        = e.left;
    r.right       = e.right;
    r.last        = last;
    due_replies.push_back(r);
  endfunction

  // sift-up on score only, parent wins ties
  function automatic void heap_insert(entry_t x);
    int slot;
    held_entries++;
    slot = held_entries;
    while (slot > 1 && $signed(kept_heap[slot / 2].score) > $signed(x.score)) begin
      kept_heap[slot] = kept_heap[slot / 2];
      slot = slot / 2;
    end
    kept_heap[slot] = x;
  endfunction

  // root replaced by last slot, then sift-down
  function automatic void heap_remove_min();
    int     slot;
    int     child;
    entry_t t;
    kept_heap[1] = kept_heap[held_entries];
    held_entries--;
    slot = 1;
    while (2 * slot <= held_entries) begin
      child = 2 * slot;
      if (child + 1 <= held_entries &&
          $signed(kept_heap[child + 1].score) < $signed(kept_heap[child].score))
        child++;
      if ($signed(kept_heap[child].score) >= $signed(kept_heap[slot].score)) break;
      t                = kept_heap[child];
      kept_heap[child] = kept_heap[slot];
      kept_heap[slot]  = t;
      slot             = child;
    end
  endfunction

  function automatic void apply_heap_item(logic [1:0] mode, entry_t x);
    int     k;
    int     i;
    int     j;
    entry_t order [CAPACITY];
    entry_t t;
    entry_t none;
    none = '0;
    case (mode)
      MODE_OFFER: begin
        k = keep_setting;
        if (k < 1) k = 1;
        if (k > CAPACITY) k = CAPACITY;
        if (held_entries < k && held_entries < CAPACITY) begin
          heap_insert(x);
          queue_reply(1'b1, 1'b0, none, 1'b1);
        end else if (held_entries == 0 ||
                     $signed(x.score) <= $signed(kept_heap[1].score)) begin
          queue_reply(1'b0, 1'b0, none, 1'b1);
        end else begin
          heap_remove_min();
          heap_insert(x);
          queue_reply(1'b1, 1'b0, none, 1'b1);
        end
      end
      MODE_CLEAR: begin
        held_entries = 0;
        queue_reply(1'b0, 1'b0, none, 1'b1);
      end
      MODE_DRAIN: begin
        if (held_entries == 0) begin
          queue_reply(1'b0, 1'b0, none, 1'b1);
        end else begin
          for (i = 0; i < held_entries; i++) order[i] = kept_heap[i + 1];
          for (i = 1; i < held_entries; i++) begin
            t = order[i];
            j = i;
            while (j > 0 && outranks(t, order[j - 1])) begin
              order[j] = order[j - 1];
              j--;
            end
            order[j] = t;
          end
          for (i = 0; i < held_entries; i++)
            queue_reply(1'b0, 1'b1, order[i], i == held_entries - 1);
          held_entries = 0;
        end
      end
      default: ;  // unused mode: no result, heap untouched
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic string describe(heap_reply_t r);
    return $sformatf("acc=%0b ev=%0b value=%0d left=%h right=%h last=%0b",
                     r.accepted, r.entry_valid, r.value, r.left, r.right, r.last);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_reply.accepted    = out_accepted;
      seen_reply.entry_valid = out_entry_valid;
      seen_reply.value       = out_value;
      seen_reply.left        = out_left;
      seen_reply.right       = out_right;
      seen_reply.last        = out_last;
      if (due_replies.size() == 0) begin
        note_mismatch({"result with nothing due: ", describe(seen_reply)});
      end else begin
        want_reply = due_replies.pop_front();
        if (seen_reply.accepted !== want_reply.accepted ||
            seen_reply.entry_valid !== want_reply.entry_valid ||
            seen_reply.value !== want_reply.value ||
            seen_reply.left !== want_reply.left ||
            seen_reply.right !== want_reply.right ||
            seen_reply.last !== want_reply.last)
          note_mismatch({"expected ", describe(want_reply), " got ", describe(seen_reply)});
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // one item; valid stays high afterwards so back-to-back items need no gap
  task automatic send_item(logic [1:0] mode, logic [SCORE_W-1:0] value,
                           logic [POS_W-1:0] left, logic [POS_W-1:0] right);
    entry_t x;
    x.score = value;
    x.left  = left;
    x.right = right;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_offer_value <= value;
    in_offer_left  <= left;
    in_offer_right <= right;
    do @(posedge clk); while (!in_ready);
    apply_heap_item(mode, x);
  endtask

  task automatic offer(logic [SCORE_W-1:0] value, logic [POS_W-1:0] left,
                       logic [POS_W-1:0] right);
    send_item(MODE_OFFER, value, left, right);
  endtask

  task automatic drain();
    send_item(MODE_DRAIN, $urandom, $urandom, $urandom);
  endtask

  // stop sending, wait for every due result, then let any trailing work finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_count(logic [KEEP_W-1:0] k);
    settle_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_KEEP_COUNT, 2'b00};
    pwdata  <= PDATA_W'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    keep_setting = k;
  endtask

  function automatic logic [SCORE_W-1:0] rand_score();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return SCORE_W'($urandom_range(8)) - SCORE_W'(4);  // dense ties
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {16'($urandom_range(7)) - 16'd3, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return $urandom_range(1) ? POS_W'($urandom) : POS_W'($urandom_range(3));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // field extremes, score ties, ignored mode, clear, empty drains
  task automatic test_directed();
    drain();
    offer(32'h7FFF_FFFF, 24'hFF_FFFF, 24'h00_0000);
    offer(32'h8000_0000, 24'h00_0000, 24'hFF_FFFF);
    offer(32'h0000_0000, 24'h00_0005, 24'h00_0009);
    offer(32'h0000_0000, 24'h00_0005, 24'h00_0003);
    offer(32'h0000_0000, 24'h00_0002, 24'hAA_AAAA);
    offer(32'hFFFF_FFFF, 24'h55_5555, 24'h55_5555);
    send_item(MODE_UNUSED, $urandom, $urandom, $urandom);
    drain();
    offer(32'h0001_0000, 24'h12_3456, 24'h65_4321);
    send_item(MODE_CLEAR, $urandom, $urandom, $urandom);
    drain();
  endtask

  // keep count of one, zero (acts as one) and above capacity
  task automatic test_keep_count_range();
    write_keep_count(6'd1);
    offer(32'd5, 24'd1, 24'd1);
    offer(32'd3, 24'd2, 24'd2);
    offer(32'd5, 24'd3, 24'd3);
    offer(32'd9, 24'd4, 24'd4);
    drain();
    write_keep_count(6'd0);
    offer(-32'sd7, 24'd1, 24'd0);
    offer(-32'sd8, 24'd2, 24'd0);
    offer(-32'sd6, 24'd3, 24'd0);
    drain();
    write_keep_count(6'd63);
    repeat (40) offer(rand_score(), rand_pos(), rand_pos());
    drain();
  endtask

  // keep count dropped below the number already held
  task automatic test_keep_lowered();
    write_keep_count(6'd8);
    repeat (6) offer(rand_score(), rand_pos(), rand_pos());
    write_keep_count(6'd2);
    repeat (5) offer(rand_score(), rand_pos(), rand_pos());
    drain();
  endtask

  // receiver holds off while items keep coming, then the sender waits it out
  task automatic test_back_pressure();
    write_keep_count(6'd32);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    repeat (10) offer(rand_score(), rand_pos(), rand_pos());
    drain();
    settle_idle();
  endtask

  // random traffic under one idling setting
  task automatic test_random_phase(int send_pct, int recv_pct, int count);
    int          pick;
    logic [5:0]  k;
    case ($urandom_range(5))
      0:       k = 6'd1;
      1:       k = 6'd32;
      2:       k = 6'd63;
      3:       k = 6'd0;
      default: k = 6'($urandom_range(12, 2));
    endcase
    write_keep_count(k);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 82) offer(rand_score(), rand_pos(), rand_pos());
      else if (pick < 91) drain();
      else if (pick < 96) send_item(MODE_CLEAR, $urandom, $urandom, $urandom);
      else send_item(MODE_UNUSED, $urandom, $urandom, $urandom);
    end
    drain();
    settle_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_OFFER;
    in_offer_value <= '0;
    in_offer_left  <= '0;
    in_offer_right <= '0;
    out_ready      <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_keep_count_range();
    test_keep_lowered();
    test_back_pressure();
    test_random_phase(0, 0, 30);
    test_random_phase(75, 0, 30);
    test_random_phase(0, 75, 30);
    test_random_phase(23, 23, 30);
    write_keep_count(KEEP_RESET);

    settle_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
